// ===== rtl/qtg_pkg.sv =====
// Shared constants and types for the quintic trajectory generator.
// No dependencies; imported by the core and the joint lane.
`default_nettype none

package qtg_pkg;

  localparam int QTG_JOINT_COUNT        = 3;
  localparam int QTG_DIV_BITS_PER_STAGE = 4;

  localparam int POS_W  = 32;  // Q3.28 position / Q11.20 velocity word
  localparam int TICK_W = 16;  // tick counts and rates
  localparam int S_W    = 33;  // s(u) in Q1.32, up to exactly one
  localparam int RATE_W = 49;  // velocity scale before per-joint multiply
  localparam int MAG_W  = 33;  // |goal - start|

  localparam logic [TICK_W-1:0] DURATION_RESET  = 16'd4000;
  localparam logic [TICK_W-1:0] TICK_RATE_RESET = 16'd1000;
  localparam logic [S_W-1:0]    ONE_Q32         = 33'h1_0000_0000;

  // per-stage load enables for the joint lanes
  typedef struct packed {
    logic j1;
    logic j2;
    logic j3;
  } qtg_lane_en_t;

endpackage

`default_nettype wire

// ===== rtl/qtg_div_pipe.sv =====
// Pipelined restoring divider, a few quotient bits per register stage.
// Carries a side payload along; standalone, no package dependency.
`default_nettype none

module qtg_div_pipe #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 16,
  parameter int BPS    = 4,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = NUM_W / BPS;

  logic [STAGES-1:0] vld;
  logic [DEN_W-1:0]  rem_q  [STAGES];
  logic [NUM_W-1:0]  nq_q   [STAGES];  // numerator bits on top, quotient shifts in below
  logic [DEN_W-1:0]  den_q  [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];

  wire [STAGES:0] en;
  assign en[STAGES] = out_ready;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic              v_src;
    logic [DEN_W-1:0]  rem_src;
    logic [DEN_W-1:0]  den_src;
    logic [NUM_W-1:0]  nq_src;
    logic [SIDE_W-1:0] side_src;
    logic [DEN_W-1:0]  rem_nx;
    logic [NUM_W-1:0]  nq_nx;

    if (g == 0) begin : g_first
      assign v_src    = in_valid;
      assign rem_src  = '0;
      assign den_src  = in_den;
      assign nq_src   = in_num;
      assign side_src = in_side;
    end else begin : g_next
      assign v_src    = vld[g-1];
      assign rem_src  = rem_q[g-1];
      assign den_src  = den_q[g-1];
      assign nq_src   = nq_q[g-1];
      assign side_src = side_q[g-1];
    end

    assign en[g] = !vld[g] || en[g+1];

    always_comb begin : step
      logic [DEN_W:0] t;
      rem_nx = rem_src;
      nq_nx  = nq_src;
      for (int b = 0; b < BPS; b++) begin
        t = {rem_nx, nq_nx[NUM_W-1]};
        if (t >= {1'b0, den_src}) begin
          rem_nx = DEN_W'(t - {1'b0, den_src});
          nq_nx  = {nq_nx[NUM_W-2:0], 1'b1};
        end else begin
          rem_nx = t[DEN_W-1:0];
          nq_nx  = {nq_nx[NUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en[g]) begin
        vld[g] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        rem_q[g]  <= rem_nx;
        nq_q[g]   <= nq_nx;
        den_q[g]  <= den_src;
        side_q[g] <= side_src;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];
  assign out_quo   = nq_q[STAGES-1];
  assign out_side  = side_q[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/qtg_lane.sv =====
// One joint lane: scales s(u) and the velocity rate by |goal - start|.
// Depends on qtg_pkg; three register stages loaded by the core's enables.
`default_nettype none

module qtg_lane
  import qtg_pkg::*;
(
  input  logic              clk,
  input  qtg_lane_en_t      en,
  input  logic [POS_W-1:0]  start_pos,
  input  logic [POS_W-1:0]  goal_pos,
  input  logic [S_W-1:0]    s_in,
  input  logic [RATE_W-1:0] rate_in,
  output logic [POS_W-1:0]  target,
  output logic [POS_W-1:0]  velocity
);

  localparam int HI_W = RATE_W - 20;
  localparam logic [42:0] MAX_POS = 43'h0_7FFF_FFFF;
  localparam logic [42:0] MAX_NEG = 43'h0_8000_0000;

  logic [32:0]      diff;
  logic             dneg;
  logic [MAG_W-1:0] dmag;

  logic [65:0]      pt;
  logic [61:0]      pa;
  logic [52:0]      pb;
  logic [POS_W-1:0] tgt2;
  logic [62:0]      vs2;
  logic [42:0]      vmag;

  // the user must keep config static while items are in flight; the lane does not enforce it
  assign diff = {goal_pos[31], goal_pos} - {start_pos[31], start_pos};

  always_ff @(posedge clk) begin
    dneg <= diff[32];
    dmag <= diff[32] ? (33'd0 - diff) : diff;
  end

  always_ff @(posedge clk) begin
    if (en.j1) begin
      pt <= 66'(s_in) * 66'(dmag);
      pa <= 62'(rate_in[RATE_W-1:20]) * 62'(dmag);
      pb <= 53'(rate_in[19:0]) * 53'(dmag);
    end
  end

  always_ff @(posedge clk) begin
    if (en.j2) begin
      tgt2 <= dneg ? (start_pos - pt[63:32]) : (start_pos + pt[63:32]);
      vs2  <= 63'(pa) + 63'(pb[52:20]);
    end
  end

  assign vmag = vs2[62:20];

  always_ff @(posedge clk) begin
    if (en.j3) begin
      target <= tgt2;
      if (dneg) begin
        velocity <= (vmag > MAX_NEG) ? 32'h8000_0000 : 32'(43'd0 - vmag);
      end else begin
        velocity <= (vmag > MAX_POS) ? 32'h7FFF_FFFF : vmag[31:0];
      end
    end
  end

  logic unused_hi;
  assign unused_hi = ^{pt[65:64], HI_W[0]};

endmodule

`default_nettype wire

// ===== rtl/quintic_trajectory_generator_core.sv =====
// Quintic smoothstep trajectory generator, top level.
// Depends on qtg_pkg, qtg_div_pipe and qtg_lane.
`default_nettype none

// Each elapsed-tick transaction yields one result transaction with a target
// position and a feedforward velocity per joint plus a segment-done flag.
// The datapath is a fully pipelined chain: one input register, a 12-stage
// divider for u = elapsed/duration, five multiply stages for the quintic
// polynomial and its derivative, a 13-stage divider that scales the
// derivative by tick_rate/duration, and three per-joint stages. A new
// transaction is taken every cycle while the pipe is not full, and each
// stage holds on backpressure independently, so bubbles fold up and the
// input keeps moving, until the pipe fills, while a finished result waits
// on m_tready. Segment registers sit on an APB port (register i at byte
// address 4*i, pready tied high) and must only be written while no
// transaction is in flight. Velocity saturates to the signed 32-bit range;
// elapsed >= duration forces target = goal, velocity = 0, segment_done = 1.
module quintic_trajectory_generator_core
  import qtg_pkg::*;
#(
  parameter int JOINT_COUNT = QTG_JOINT_COUNT,
  localparam int REG_COUNT = 2 * JOINT_COUNT + 2,
  localparam int ADDR_W    = $clog2(4 * REG_COUNT)
) (
  input  logic                       clk,
  input  logic                       rst,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,   // elapsed_ticks
  // result stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // target_a.. then velocity_a.., 32 bits each, lowest joint first
  output logic [JOINT_COUNT*64-1:0]  m_tdata,
  output logic [0:0]                 m_tuser,   // segment_done
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int IDX_W   = ADDR_W - 2;
  localparam int DIV1_W  = 48;
  localparam int DIV2_W  = 52;

  // ---------------- configuration registers ----------------
  logic [POS_W-1:0]  start_q [JOINT_COUNT];
  logic [POS_W-1:0]  goal_q  [JOINT_COUNT];
  logic [TICK_W-1:0] dur_q;
  logic [TICK_W-1:0] rate_q;
  logic [IDX_W-1:0]  idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        start_q[j] <= '0;
        goal_q[j]  <= '0;
      end
      dur_q  <= DURATION_RESET;
      rate_q <= TICK_RATE_RESET;
    end else if (wr) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        if (idx == IDX_W'(j)) start_q[j] <= pwdata;
        if (idx == IDX_W'(JOINT_COUNT + j)) goal_q[j] <= pwdata;
      end
      if (idx == IDX_W'(2 * JOINT_COUNT)) dur_q <= pwdata[15:0];
      if (idx == IDX_W'(2 * JOINT_COUNT + 1)) rate_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      if (idx == IDX_W'(j)) prdata = start_q[j];
      if (idx == IDX_W'(JOINT_COUNT + j)) prdata = goal_q[j];
    end
    if (idx == IDX_W'(2 * JOINT_COUNT)) prdata = {16'd0, dur_q};
    if (idx == IDX_W'(2 * JOINT_COUNT + 1)) prdata = {16'd0, rate_q};
  end

  // ---------------- input register ----------------
  logic              v0;
  logic              en0;
  logic [TICK_W-1:0] e0;
  logic              done0;
  logic              d1_in_ready;

  assign en0      = !v0 || d1_in_ready;
  assign s_tready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      e0    <= s_tdata;
      done0 <= (s_tdata >= dur_q);
    end
  end

  // ---------------- u = elapsed * 2^32 / duration ----------------
  logic              d1_valid;
  logic [DIV1_W-1:0] d1_quo;
  logic              d1_side;
  logic [4:0]        mv;       // valids of M1..M5
  wire  [4:0]        en_m;
  logic              d2_in_ready;

  qtg_div_pipe #(
    .NUM_W  (DIV1_W),
    .DEN_W  (TICK_W),
    .BPS    (QTG_DIV_BITS_PER_STAGE),
    .SIDE_W (1)
  ) u_div_u (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_ready  (d1_in_ready),
    .in_num    ({e0, 32'd0}),
    .in_den    (dur_q),
    .in_side   (done0),
    .out_valid (d1_valid),
    .out_ready (en_m[0]),
    .out_quo   (d1_quo),
    .out_side  (d1_side)
  );

  assign en_m[4] = !mv[4] || d2_in_ready;
  assign en_m[3] = !mv[3] || en_m[4];
  assign en_m[2] = !mv[2] || en_m[3];
  assign en_m[1] = !mv[1] || en_m[2];
  assign en_m[0] = !mv[0] || en_m[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else begin
      if (en_m[0]) mv[0] <= d1_valid;
      if (en_m[1]) mv[1] <= mv[0];
      if (en_m[2]) mv[2] <= mv[1];
      if (en_m[3]) mv[3] <= mv[2];
      if (en_m[4]) mv[4] <= mv[3];
    end
  end

  // M1: u^2 and w = 1 - u
  logic [31:0] u1, u2_1, w1;
  logic        done1;
  logic [63:0] uu;

  assign uu = 64'(d1_quo[31:0]) * 64'(d1_quo[31:0]);

  always_ff @(posedge clk) begin
    if (en_m[0]) begin
      u1    <= d1_quo[31:0];
      u2_1  <= uu[63:32];
      w1    <= 32'd0 - d1_quo[31:0];
      done1 <= d1_side;
    end
  end

  // M2: u^3, w^2, polynomial 10 - 15u + 6u^2 in Q4.28
  logic [31:0] u3_2, w2_2, p28_2, u2_2;
  logic        done2;
  logic [63:0] u3p, wwp;
  logic [37:0] poly;

  assign u3p  = 64'(u2_1) * 64'(u1);
  assign wwp  = 64'(w1) * 64'(w1);
  assign poly = (38'd10 << 32) + 38'(u2_1) * 38'd6 - 38'(u1) * 38'd15;

  always_ff @(posedge clk) begin
    if (en_m[1]) begin
      u3_2  <= u3p[63:32];
      w2_2  <= wwp[63:32];
      p28_2 <= poly[35:4];
      u2_2  <= u2_1;
      done2 <= done1;
    end
  end

  // M3: s raw and u^2 w^2
  logic [35:0] s3;
  logic [31:0] q3;
  logic        done3;
  logic [63:0] sp, qp;

  assign sp = 64'(u3_2) * 64'(p28_2);
  assign qp = 64'(u2_2) * 64'(w2_2);

  always_ff @(posedge clk) begin
    if (en_m[2]) begin
      s3    <= sp[63:28];
      q3    <= qp[63:32];
      done3 <= done2;
    end
  end

  // M4: clamp s to one, ds = 30 * u^2 w^2 (bounded below 2^33)
  logic [S_W-1:0] s4;
  logic [32:0]    ds4;
  logic           done4;
  logic [36:0]    ds;

  assign ds = (37'(q3) << 5) - (37'(q3) << 1);

  always_ff @(posedge clk) begin
    if (en_m[3]) begin
      if (done3 || (s3 > 36'(ONE_Q32))) begin
        s4 <= ONE_Q32;
      end else begin
        s4 <= s3[S_W-1:0];
      end
      ds4   <= ds[32:0];
      done4 <= done3;
    end
  end

  // M5: ds * tick_rate
  logic [RATE_W-1:0] num5;
  logic [S_W-1:0]    s5;
  logic              done5;

  always_ff @(posedge clk) begin
    if (en_m[4]) begin
      num5  <= RATE_W'(ds4) * RATE_W'(rate_q);
      s5    <= s4;
      done5 <= done4;
    end
  end

  // ---------------- rate = ds * tick_rate / duration ----------------
  logic              d2_valid;
  logic [DIV2_W-1:0] d2_quo;
  logic [S_W:0]      d2_side;
  logic [2:0]        jv;
  wire  [2:0]        en_j;

  qtg_div_pipe #(
    .NUM_W  (DIV2_W),
    .DEN_W  (TICK_W),
    .BPS    (QTG_DIV_BITS_PER_STAGE),
    .SIDE_W (S_W + 1)
  ) u_div_rate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mv[4]),
    .in_ready  (d2_in_ready),
    .in_num    ({(DIV2_W - RATE_W)'(0), num5}),
    .in_den    (dur_q),
    .in_side   ({done5, s5}),
    .out_valid (d2_valid),
    .out_ready (en_j[0]),
    .out_quo   (d2_quo),
    .out_side  (d2_side)
  );

  // ---------------- joint lanes ----------------
  assign en_j[2] = !jv[2] || m_tready;
  assign en_j[1] = !jv[1] || en_j[2];
  assign en_j[0] = !jv[0] || en_j[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      jv <= '0;
    end else begin
      if (en_j[0]) jv[0] <= d2_valid;
      if (en_j[1]) jv[1] <= jv[0];
      if (en_j[2]) jv[2] <= jv[1];
    end
  end

  logic done_j1, done_j2, done_j3;

  always_ff @(posedge clk) begin
    if (en_j[0]) done_j1 <= d2_side[S_W];
    if (en_j[1]) done_j2 <= done_j1;
    if (en_j[2]) done_j3 <= done_j2;
  end

  qtg_lane_en_t      lane_en;
  logic [RATE_W-1:0] rate_eff;
  logic [POS_W-1:0]  tgt_w [JOINT_COUNT];
  logic [POS_W-1:0]  vel_w [JOINT_COUNT];

  assign lane_en.j1 = en_j[0];
  assign lane_en.j2 = en_j[1];
  assign lane_en.j3 = en_j[2];

  // segment end: no velocity
  assign rate_eff = d2_side[S_W] ? '0 : d2_quo[RATE_W-1:0];

  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_joint
    qtg_lane u_lane (
      .clk       (clk),
      .en        (lane_en),
      .start_pos (start_q[j]),
      .goal_pos  (goal_q[j]),
      .s_in      (d2_side[S_W-1:0]),
      .rate_in   (rate_eff),
      .target    (tgt_w[j]),
      .velocity  (vel_w[j])
    );

    assign m_tdata[j*32 +: 32]                 = tgt_w[j];
    assign m_tdata[(JOINT_COUNT + j)*32 +: 32] = vel_w[j];
  end

  assign m_tvalid   = jv[2];
  assign m_tuser[0] = done_j3;

endmodule

`default_nettype wire

// ===== sim/tb_quintic_trajectory_generator_core.sv =====
// Self-checking testbench for the quintic trajectory generator core.
// Depends on qtg_pkg and quintic_trajectory_generator_core; needs no files.
`default_nettype none

module tb_quintic_trajectory_generator_core
  import qtg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJ       = QTG_JOINT_COUNT;
  localparam int NREG     = 2 * NJ + 2;
  localparam int AW       = $clog2(4 * NREG);
  localparam int LATENCY  = 34;
  localparam int WDOG_MAX = 20000;

  // register indexes
  localparam int REG_START_A  = 0;
  localparam int REG_GOAL_A   = NJ;
  localparam int REG_DURATION = 2 * NJ;
  localparam int REG_TICKRATE = 2 * NJ + 1;

  typedef struct {
    logic [NJ*32-1:0] tgt;
    logic [NJ*32-1:0] vel;
    logic             done;
  } traj_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [NJ*64-1:0] m_tdata;  // target_a.., then velocity_a.., 32 bits each
  logic [0:0] m_tuser;        // segment_done
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  quintic_trajectory_generator_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the segment registers
  logic signed [31:0] seg_start [NJ];
  logic signed [31:0] seg_goal  [NJ];
  logic [15:0] seg_duration;
  logic [15:0] seg_tick_rate;

  logic [15:0]  tick_queue[$];     // elapsed counts waiting to be sent
  traj_point_t  expected_pts[$];   // predicted results, oldest first
  int  send_idle_pct = 0, recv_stall_pct = 0;
  int  errors = 0;
  int  wdog = 0;

  // input acceptance seen at the last rising edge
  logic s_tready_q = 1'b0;

  // Predicted trajectory point for one elapsed count, current segment.
  function automatic traj_point_t plan_point(input logic [15:0] elapsed);
    traj_point_t pt;
    logic [63:0] u, u2, u3, p, s, w, w2, ds, rate, hi, lo, mag, off, vm;
    logic signed [63:0] d, tgt, vel;
    rate = '0;
    pt.done = (elapsed >= seg_duration);
    if (pt.done) begin
      s = 64'h1_0000_0000;
    end else begin
      u  = ({48'd0, elapsed} << 32) / seg_duration;
      u2 = (u * u) >> 32;
      u3 = (u2 * u) >> 32;
      p  = (64'd10 << 32) + 6 * u2 - 15 * u;
      s  = (u3 * (p >> 4)) >> 28;
      if (s > 64'h1_0000_0000) s = 64'h1_0000_0000;
      if (u != 0) begin
        w    = 64'h1_0000_0000 - u;
        w2   = (w * w) >> 32;
        ds   = 30 * ((u2 * w2) >> 32);
        rate = (ds * seg_tick_rate) / seg_duration;
      end
    end
    for (int j = 0; j < NJ; j++) begin
      d   = 64'(seg_goal[j]) - 64'(seg_start[j]);
      mag = (d < 0) ? 64'(-d) : 64'(d);
      off = (s * mag) >> 32;
      tgt = (d < 0) ? 64'(seg_start[j]) - 64'(off) : 64'(seg_start[j]) + 64'(off);
      // split multiply keeps rate*|d| inside 64 bits
      hi  = rate >> 20;
      lo  = rate & 64'hF_FFFF;
      vm  = (hi * mag + ((lo * mag) >> 20)) >> 20;
      if (d < 0) vel = (vm > 64'h8000_0000) ? -64'sh8000_0000 : -64'(vm);
      else       vel = (vm > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : 64'(vm);
      pt.tgt[j*32 +: 32] = tgt[31:0];
      pt.vel[j*32 +: 32] = vel[31:0];
    end
    return pt;
  endfunction

  // Driver: pops pending ticks, idles at random, stalls m_tready at random.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_q) begin
        if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= tick_queue.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on input transactions, checks output transactions.
  always @(posedge clk) begin
    traj_point_t exp_pt;
    s_tready_q <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_pts = {expected_pts, plan_point(s_tdata)};
      end
      if (m_tvalid && m_tready) begin
        if (expected_pts.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          exp_pt = expected_pts.pop_front();
          for (int j = 0; j < NJ; j++) begin
            if (m_tdata[j*32 +: 32] !== exp_pt.tgt[j*32 +: 32]) begin
              $error("target_%c exp %h got %h", 8'(97 + j), exp_pt.tgt[j*32 +: 32],
                     m_tdata[j*32 +: 32]);
              errors++;
            end
            if (m_tdata[NJ*32 + j*32 +: 32] !== exp_pt.vel[j*32 +: 32]) begin
              $error("velocity_%c exp %h got %h", 8'(97 + j), exp_pt.vel[j*32 +: 32],
                     m_tdata[NJ*32 + j*32 +: 32]);
              errors++;
            end
          end
          if (m_tuser[0] !== exp_pt.done) begin
            $error("segment_done exp %0b got %0b", exp_pt.done, m_tuser[0]);
            errors++;
          end
        end
      end
      // watchdog on silent cycles
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel ||
          (tick_queue.size() == 0 && expected_pts.size() == 0))
        wdog = 0;
      else
        wdog++;
      if (wdog >= WDOG_MAX) begin
        $display("quintic_trajectory_generator_core regression: fail");
        $finish;
      end
    end
  end

  // APB write: setup then access; pready is tied high.
  task automatic write_reg(input int idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AW'(4 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < REG_GOAL_A)          seg_start[idx]        = val;
    else if (idx < REG_DURATION)   seg_goal[idx - NJ]    = val;
    else if (idx == REG_DURATION)  seg_duration          = val[15:0];
    else                           seg_tick_rate         = val[15:0];
  endtask

  task automatic load_segment(input logic [31:0] st [NJ], input logic [31:0] gl [NJ],
                              input logic [15:0] dur, input logic [15:0] rt);
    for (int j = 0; j < NJ; j++) write_reg(REG_START_A + j, st[j]);
    for (int j = 0; j < NJ; j++) write_reg(REG_GOAL_A + j, gl[j]);
    write_reg(REG_DURATION, {16'd0, dur});
    write_reg(REG_TICKRATE, {16'd0, rt});
  endtask

  // Let the queue drain and the pipe empty before touching registers.
  task automatic drain_pipe();
    while (tick_queue.size() > 0 || expected_pts.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos(input int kind);
    case (kind)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] st [NJ];
    logic [31:0] gl [NJ];
    logic [15:0] dur;
    int n_items, seg_len;
    for (int j = 0; j < NJ; j++) begin
      seg_start[j] = 0;
      seg_goal[j]  = 0;
    end
    seg_duration  = DURATION_RESET;
    seg_tick_rate = TICK_RATE_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset segment, then extreme swings with extreme rates.
    tick_queue = '{16'd0, 16'd1, 16'd2000, 16'd3999, 16'd4000, 16'hFFFF};
    drain_pipe();
    for (int j = 0; j < NJ; j++) begin
      st[j] = (j == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      gl[j] = (j == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    gl[2] = st[2];  // hold joint
    load_segment(st, gl, 16'd3, 16'hFFFF);
    tick_queue = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'hFFFF};
    drain_pipe();
    load_segment(st, gl, 16'hFFFF, 16'd1);
    tick_queue = '{16'd0, 16'd1, 16'h7FFF, 16'h8000, 16'hAAAA, 16'h5555,
                   16'hFFFE, 16'hFFFF};
    drain_pipe();
    // zero duration and zero rate written through unchecked bits
    load_segment(st, gl, 16'd0, 16'd0);
    tick_queue = '{16'd0, 16'd7, 16'hFFFF};
    drain_pipe();

    // Random segments, sweeping through idling phases.
    n_items = 0;
    for (int seg = 0; n_items < 800; seg++) begin
      case ((seg / 4) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int j = 0; j < NJ; j++) begin
        st[j] = rand_pos($urandom_range(5));
        gl[j] = ($urandom_range(7) == 0) ? st[j] : rand_pos($urandom_range(5));
      end
      case ($urandom_range(3))
        0: dur = 16'($urandom_range(1, 8));
        1: dur = 16'($urandom_range(1, 300));
        2: dur = 16'($urandom);
        default: dur = 16'hFFFF;
      endcase
      load_segment(st, gl, dur, $urandom_range(9) == 0 ? 16'hFFFF : 16'($urandom));
      seg_len = $urandom_range(10, 50);
      for (int k = 0; k < seg_len; k++) begin
        if ($urandom_range(4) == 0) tick_queue = {tick_queue, 16'($urandom)};
        else tick_queue = {tick_queue, 16'($urandom_range(0, int'(dur) + 1 > 65535 ?
                                                          65535 : int'(dur) + 1))};
      end
      n_items += seg_len;
      drain_pipe();
    end

    if (errors == 0 && expected_pts.size() == 0)
      $display("quintic_trajectory_generator_core regression: pass");
    else
      $display("quintic_trajectory_generator_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
